// File: rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and codes for the circular deque
// Command and error codes, field widths and the controller-to-datapath
// command bundle.
// ----------------------------------------------------------------------------
package cdq_pkg;

  // Field widths
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned ERR_W   = 2;

  // Default store depth
  localparam int unsigned DEPTH_DEFAULT = 16;

  // Operation codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NOP        = 3'd4;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;   // capture the incoming word
    logic exec;   // write the store and move the pointers
    logic read;   // read front and back entries
  } ctrl_t;

endpackage

// File: rtl/circular_deque_unit.sv
// ----------------------------------------------------------------------------
// circular_deque_unit: double-ended queue in a circular word store
// Push or pop at either end, with front/back values, flags, count and error
// code returned for every command.
//
//   channel   ports                                      handshake
//   --------  -----------------------------------------  -------------------
//   command   cmd_i, data_in_i                           start_i, busy_o
//   result    front_value_o, back_value_o, is_empty_o,   result_valid_o
//             is_full_o, entry_count_o, error_code_o     (one-cycle strobe)
//
// A word is taken when start_i is high and busy_o is low. In the update state
// that follows, the store is written and the pointers move; in the read state
// after it, the front and back entries are read on two read ports; the result
// is then strobed for one cycle, during which the next word may be taken. No
// word is taken while busy_o is high. Reset clears the head pointer and the
// count only; the store needs no clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
module circular_deque_unit #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [cdq_pkg::CMD_W-1:0]         cmd_i,
  input  logic signed [cdq_pkg::WORD_W-1:0] data_in_i,
  output logic                              result_valid_o,
  output logic signed [cdq_pkg::WORD_W-1:0] front_value_o,
  output logic signed [cdq_pkg::WORD_W-1:0] back_value_o,
  output logic                              is_empty_o,
  output logic                              is_full_o,
  output logic [cdq_pkg::CNT_W-1:0]         entry_count_o,
  output logic [cdq_pkg::ERR_W-1:0]         error_code_o
);
  import cdq_pkg::*;

  ctrl_t ctrl;

  // Sequence the operation
  cdq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .ctrl_o         (ctrl)
  );

  // Store and pointers
  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cmd_i         (cmd_i),
    .data_in_i     (data_in_i),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o),
    .entry_count_o (entry_count_o),
    .error_code_o  (error_code_o)
  );

endmodule

// File: rtl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl: sequencing controller for the circular deque
// One-hot state machine that takes a word, steps the datapath through its
// update and read cycles, and strobes the result.
// ----------------------------------------------------------------------------
module cdq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  output logic           result_valid_o,
  output cdq_pkg::ctrl_t ctrl_o
);
  import cdq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // Take a word when idle or while the last result is shown
  assign accept = start_i && ((state_q == S_IDLE) || (state_q == S_RESP));

  // Advance the sequence
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  state_d = accept ? S_EXEC : S_IDLE;
      S_EXEC:  state_d = S_READ;
      S_READ:  state_d = S_RESP;
      S_RESP:  state_d = accept ? S_EXEC : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Drive datapath commands and handshake outputs
  assign ctrl_o.load    = accept;
  assign ctrl_o.exec    = (state_q == S_EXEC);
  assign ctrl_o.read    = (state_q == S_READ);
  assign busy_o         = (state_q == S_EXEC) || (state_q == S_READ);
  assign result_valid_o = (state_q == S_RESP);

  // Assertions
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && ctrl_o.exec))
    else $error("accepted word did not start an update");

  a_result_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(ctrl_o.read) && !busy_o))
    else $error("result strobe without a preceding read cycle");

endmodule

// File: rtl/cdq_datapath.sv
// ----------------------------------------------------------------------------
// cdq_datapath: storage and pointer logic for the circular deque
// Holds the entry store, head pointer and occupancy, applies one operation
// per update cycle and reads the front and back entries into registers.
// ----------------------------------------------------------------------------
module cdq_datapath #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cdq_pkg::ctrl_t              ctrl_i,
  input  logic [cdq_pkg::CMD_W-1:0]   cmd_i,
  input  logic signed [cdq_pkg::WORD_W-1:0] data_in_i,
  output logic signed [cdq_pkg::WORD_W-1:0] front_value_o,
  output logic signed [cdq_pkg::WORD_W-1:0] back_value_o,
  output logic                        is_empty_o,
  output logic                        is_full_o,
  output logic [cdq_pkg::CNT_W-1:0]   entry_count_o,
  output logic [cdq_pkg::ERR_W-1:0]   error_code_o
);
  import cdq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Wrap a sum below twice the depth back into the store
  function automatic logic [AW-1:0] wrap_idx(input logic [AW:0] sum);
    logic [AW:0] red;
    red = (sum >= (AW+1)'(DEPTH)) ? (sum - (AW+1)'(DEPTH)) : sum;
    return red[AW-1:0];
  endfunction

  logic [WORD_W-1:0] store_q [DEPTH];

  logic [CMD_W-1:0]  cmd_q;
  logic [WORD_W-1:0] data_q;
  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     occ_q, occ_d;
  logic [ERR_W-1:0]  err_q, err_d;
  logic [WORD_W-1:0] rd_front_q, rd_back_q;

  logic              full, empty;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     head_dec, tail_idx, back_idx;
  logic [AW:0]       head_occ;
  logic [CW+CNT_W-1:0] cnt_ext;

  // Capture the accepted word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= cmd_i;
      data_q <= data_in_i;
    end
  end

  assign full     = (occ_q == CW'(DEPTH));
  assign empty    = (occ_q == '0);
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : (head_q - AW'(1));
  assign head_occ = {1'b0, head_q} + (AW+1)'(occ_q);
  assign tail_idx = wrap_idx(head_occ);
  assign back_idx = wrap_idx(head_occ - (AW+1)'(1));

  // Decode the operation into pointer moves and a store write
  always_comb begin
    head_d  = head_q;
    occ_d   = occ_q;
    err_d   = ERR_NONE;
    wr_en   = 1'b0;
    wr_addr = tail_idx;
    unique case (cmd_q)
      CMD_PUSH_FRONT: begin
        if (full) begin
          err_d = ERR_FULL;
        end else begin
          head_d  = head_dec;
          occ_d   = occ_q + CW'(1);
          wr_en   = 1'b1;
          wr_addr = head_dec;
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          err_d = ERR_FULL;
        end else begin
          occ_d = occ_q + CW'(1);
          wr_en = 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          err_d = ERR_EMPTY;
        end else begin
          head_d = wrap_idx({1'b0, head_q} + (AW+1)'(1));
          occ_d  = occ_q - CW'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          err_d = ERR_EMPTY;
        end else begin
          occ_d = occ_q - CW'(1);
        end
      end
      default: begin
        // no operation, unused codes included
      end
    endcase
  end

  // Update pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      occ_q  <= '0;
    end else if (ctrl_i.exec) begin
      head_q <= head_d;
      occ_q  <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      err_q <= err_d;
    end
  end

  // Write the store
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec && wr_en) begin
      store_q[wr_addr] <= data_q;
    end
  end

  // Read front and back entries
  always_ff @(posedge clk_i) begin
    if (ctrl_i.read) begin
      rd_front_q <= store_q[head_q];
      rd_back_q  <= store_q[back_idx];
    end
  end

  // Drive result fields, zero values when empty
  assign cnt_ext       = {{CNT_W{1'b0}}, occ_q};
  assign front_value_o = empty ? '0 : rd_front_q;
  assign back_value_o  = empty ? '0 : rd_back_q;
  assign is_empty_o    = empty;
  assign is_full_o     = full;
  assign entry_count_o = cnt_ext[CNT_W-1:0];
  assign error_code_o  = err_q;

  // Assertions
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_refused_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.exec && (err_d != ERR_NONE)) |=>
      ((occ_q == $past(occ_q)) && (head_q == $past(head_q))))
    else $error("refused operation moved the pointers");

endmodule
